// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; define NO_ASSERTIONS to
// compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/htd_pkg.sv =====
// ---------------------------------------------------------------------------
// htd_pkg
// Constants and codes of the code trie decoder.
// ---------------------------------------------------------------------------
package htd_pkg;

  // Default sizing of the node store and code table.
  localparam int MAX_NODES_DEF    = 1024;
  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int SYMBOL_BITS_DEF  = 9;

  // Fixed field widths.
  localparam int OP_W       = 2;
  localparam int CODE_LEN_W = 5;
  localparam int CODE_W     = 16;
  localparam int STATUS_W   = 2;

  // Request operations.
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SYMBOL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DAMAGED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

endpackage

// ===== rtl/huffman_trie_decoder_core.sv =====
// ---------------------------------------------------------------------------
// huffman_trie_decoder_core
// Binary code trie held in a synchronous node store; built by insert
// requests and walked one stream bit per decode request.
// ---------------------------------------------------------------------------
// Every request returns exactly one result, in order. A clear request empties
// the trie to a bare root (accept, result). An insert walks the code from bit
// code_length-1 down: a step through an existing child issues a read of the
// node store (one read port, registered read) and takes the child in a
// separate read state, a step that creates a child stays in the step state,
// and the end node is marked before the result. A decode fetches the child
// and then gives the result, or goes straight to the result when the child
// is missing; in either case, the node at a non-root decode position is
// first fetched again on the first decode after an insert, and again after
// a damaged path found on such a fetch. The root node lives in flip-flops,
// so reset and clear empty it at once; every other entry is written by the
// insert that creates it, so no clearing pass is needed. A request can be
// accepted while the previous result still waits on a stalled output.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_trie_decoder_core #(
  parameter int MAX_NODES    = htd_pkg::MAX_NODES_DEF,
  parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_BITS  = htd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [htd_pkg::OP_W-1:0]       op,
  input  logic [SYMBOL_BITS-1:0]        symbol,
  input  logic [htd_pkg::CODE_LEN_W-1:0] code_length,
  input  logic [htd_pkg::CODE_W-1:0]     code_value,
  input  logic                          bit_req,
  // result channel
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [htd_pkg::STATUS_W-1:0]   status,
  output logic [SYMBOL_BITS-1:0]        decoded_symbol
);

  import htd_pkg::*;

  // Node index, node count, remaining code bits and code shift widths.
  localparam int NW  = $clog2(MAX_NODES);
  localparam int UW  = NW + 1;
  localparam int RW  = $clog2(MAX_CODE_LEN + 1);
  localparam int SHW = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int IW  = $clog2(SHW);

  // One trie node; a child index of zero means no child (the root is never
  // a child).
  typedef struct packed {
    logic [NW-1:0]          left;
    logic [NW-1:0]          right;
    logic                   term;
    logic [SYMBOL_BITS-1:0] sym;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INS_STEP = 6'b000010,
    S_INS_READ = 6'b000100,
    S_DEC_CUR  = 6'b001000,
    S_DEC_READ = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

  // Control state
  state_t        state, state_next;
  logic [UW-1:0] nodes_used, nodes_used_next;
  logic [NW-1:0] pos, pos_next;
  logic          cache_ok, cache_ok_next;
  node_t         root, root_next;
  logic          cur_dirty, cur_dirty_next;
  logic          res_valid_next;

  // Working registers
  logic [NW-1:0]          cur, cur_next;
  node_t                  cur_data, cur_data_next;
  logic [RW-1:0]          rem, rem_next;
  logic [SHW-1:0]         code_sh, code_sh_next;
  logic [SYMBOL_BITS-1:0] sym_r, sym_r_next;
  logic                   bit_r, bit_r_next;
  node_t                  cache, cache_next;
  logic [STATUS_W-1:0]    pend_status, pend_status_next;
  logic [SYMBOL_BITS-1:0] pend_sym, pend_sym_next;
  logic [STATUS_W-1:0]    status_next;
  logic [SYMBOL_BITS-1:0] decoded_symbol_next;

  // Node store
  logic [NODE_W-1:0] node_mem [MAX_NODES];
  node_t             rd_data;
  logic              mem_we;
  logic [NW-1:0]     mem_waddr;
  node_t             mem_wdata;
  logic              mem_re;
  logic [NW-1:0]     mem_raddr;

  // Decode step: the node at the decode position comes from the root
  // registers, the position cache or a fresh read.
  node_t         dec_src;
  logic          dec_bit;
  logic [NW-1:0] dec_nxt;

  // Insert step
  logic [IW-1:0] ins_idx;
  logic          ins_bit;
  logic [NW-1:0] ins_slot;
  node_t         ins_upd;
  node_t         ins_mark;

  assign req_stall = (state != S_IDLE);

  assign dec_src = (state == S_DEC_CUR) ? rd_data : ((pos == '0) ? root : cache);
  assign dec_bit = (state == S_DEC_CUR) ? bit_r : bit_req;
  assign dec_nxt = dec_bit ? dec_src.right : dec_src.left;

  assign ins_idx  = IW'(rem - RW'(1));
  assign ins_bit  = code_sh[ins_idx];
  assign ins_slot = ins_bit ? cur_data.right : cur_data.left;

  always_comb begin
    ins_upd = cur_data;
    if (ins_bit) begin
      ins_upd.right = nodes_used[NW-1:0];
    end else begin
      ins_upd.left = nodes_used[NW-1:0];
    end
    ins_mark      = cur_data;
    ins_mark.term = 1'b1;
    ins_mark.sym  = sym_r;
  end

  always_comb begin
    state_next          = state;
    nodes_used_next     = nodes_used;
    pos_next            = pos;
    cache_ok_next       = cache_ok;
    root_next           = root;
    cur_dirty_next      = cur_dirty;
    cur_next            = cur;
    cur_data_next       = cur_data;
    rem_next            = rem;
    code_sh_next        = code_sh;
    sym_r_next          = sym_r;
    bit_r_next          = bit_r;
    cache_next          = cache;
    pend_status_next    = pend_status;
    pend_sym_next       = pend_sym;
    status_next         = status;
    decoded_symbol_next = decoded_symbol;
    mem_we              = 1'b0;
    mem_waddr           = cur;
    mem_wdata           = cur_data;
    mem_re              = 1'b0;
    mem_raddr           = cur;

    // Drop the result once it has been taken.
    res_valid_next = res_valid && res_stall;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          pend_sym_next = '0;
          case (op)
            OP_CLEAR: begin
              nodes_used_next  = UW'(1);
              root_next        = '0;
              pos_next         = '0;
              cache_ok_next    = 1'b0;
              pend_status_next = ST_DONE;
              state_next       = S_RESP;
            end
            OP_INSERT: begin
              // The walk may rewrite the node under the decode position.
              cache_ok_next  = 1'b0;
              cur_next       = '0;
              cur_data_next  = root;
              cur_dirty_next = 1'b0;
              sym_r_next     = symbol;
              code_sh_next   = SHW'(code_value);
              if (int'(code_length) > MAX_CODE_LEN) begin
                rem_next = RW'(MAX_CODE_LEN);
              end else begin
                rem_next = RW'(code_length);
              end
              state_next = S_INS_STEP;
            end
            OP_DECODE: begin
              bit_r_next = bit_req;
              if (pos != '0 && !cache_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = pos;
                state_next = S_DEC_CUR;
              end else if (dec_nxt == '0) begin
                pend_status_next = ST_DAMAGED;
                state_next       = S_RESP;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = dec_nxt;
                cur_next   = dec_nxt;
                state_next = S_DEC_READ;
              end
            end
            default: begin
              pend_status_next = ST_DONE;
              state_next       = S_RESP;
            end
          endcase
        end
      end

      S_INS_STEP: begin
        if (rem == '0) begin
          // End of the code: mark the node terminal with the symbol.
          if (cur == '0) begin
            root_next = ins_mark;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = cur;
            mem_wdata = ins_mark;
          end
          cur_dirty_next   = 1'b0;
          pend_status_next = ST_DONE;
          state_next       = S_RESP;
        end else if (ins_slot != '0) begin
          // Existing child: fetch it.
          mem_re     = 1'b1;
          mem_raddr  = ins_slot;
          cur_next   = ins_slot;
          rem_next   = rem - RW'(1);
          state_next = S_INS_READ;
        end else if (nodes_used == UW'(MAX_NODES)) begin
          // Store full: keep what was built, flush a fresh node still held.
          if (cur_dirty) begin
            mem_we    = 1'b1;
            mem_waddr = cur;
            mem_wdata = cur_data;
          end
          cur_dirty_next   = 1'b0;
          pend_status_next = ST_FULL;
          state_next       = S_RESP;
        end else begin
          // Create the child: write back the parent, hold the fresh node.
          if (cur == '0) begin
            root_next = ins_upd;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = cur;
            mem_wdata = ins_upd;
          end
          nodes_used_next = nodes_used + UW'(1);
          cur_next        = nodes_used[NW-1:0];
          cur_data_next   = '0;
          cur_dirty_next  = 1'b1;
          rem_next        = rem - RW'(1);
        end
      end

      S_INS_READ: begin
        cur_data_next  = rd_data;
        cur_dirty_next = 1'b0;
        state_next     = S_INS_STEP;
      end

      S_DEC_CUR: begin
        if (dec_nxt == '0) begin
          pend_status_next = ST_DAMAGED;
          state_next       = S_RESP;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = dec_nxt;
          cur_next   = dec_nxt;
          state_next = S_DEC_READ;
        end
      end

      S_DEC_READ: begin
        if (rd_data.term) begin
          pend_status_next = ST_SYMBOL;
          pend_sym_next    = rd_data.sym;
          pos_next         = '0;
          cache_ok_next    = 1'b0;
        end else begin
          pend_status_next = ST_DONE;
          pos_next         = cur;
          cache_next       = rd_data;
          cache_ok_next    = 1'b1;
        end
        state_next = S_RESP;
      end

      S_RESP: begin
        if (!res_valid || !res_stall) begin
          res_valid_next      = 1'b1;
          status_next         = pend_status;
          decoded_symbol_next = pend_sym;
          state_next          = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nodes_used <= UW'(1);
      pos        <= '0;
      cache_ok   <= 1'b0;
      root       <= '0;
      cur_dirty  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      nodes_used <= nodes_used_next;
      pos        <= pos_next;
      cache_ok   <= cache_ok_next;
      root       <= root_next;
      cur_dirty  <= cur_dirty_next;
      res_valid  <= res_valid_next;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    cur            <= cur_next;
    cur_data       <= cur_data_next;
    rem            <= rem_next;
    code_sh        <= code_sh_next;
    sym_r          <= sym_r_next;
    bit_r          <= bit_r_next;
    cache          <= cache_next;
    pend_status    <= pend_status_next;
    pend_sym       <= pend_sym_next;
    status         <= status_next;
    decoded_symbol <= decoded_symbol_next;
  end

  // Node store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= node_t'(node_mem[mem_raddr]);
    end
  end

  `ASSERT_ALWAYS(a_used_range, clk, rst,
                 (nodes_used >= UW'(1)) && (nodes_used <= UW'(MAX_NODES)),
                 "node count out of range")
  `ASSERT_IMPLIES(a_dirty_not_root, clk, rst, cur_dirty, cur != '0,
                  "fresh node held at root index")
  `ASSERT_IMPLIES(a_cache_off_root, clk, rst, cache_ok, pos != '0,
                  "position cache valid at root")
  `ASSERT_IMPLIES(a_sym_only_hit, clk, rst, res_valid && (status != ST_SYMBOL),
                  decoded_symbol == '0, "symbol without hit")

endmodule

// ===== bench/tb_huffman_trie_decoder_core.sv =====
// ---------------------------------------------------------------------------
// tb_huffman_trie_decoder_core
// Self-checking bench for the code trie decoder. A directed table of
// requests covers the reset state, field extremes and the corner cases of
// insert and decode. Random phases follow: prefix code tables are built and
// then streamed bit by bit, the node store is driven to overflow, and raw
// noise requests are mixed in. Every result is checked against the typed
// result of its directed row or else a trie model kept inside the bench.
// The sender idles in bursts and the receiver stalls on its own pattern.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_huffman_trie_decoder_core;
  import htd_pkg::*;

  localparam int MAX_NODES    = MAX_NODES_DEF;
  localparam int MAX_CODE_LEN = MAX_CODE_LEN_DEF;
  localparam int SYM_W        = SYMBOL_BITS_DEF;
  localparam int NODE_W       = $clog2(MAX_NODES);
  localparam int TARGET_REQS  = 1850;
  // Longest correct quiet stretch is a long insert behind a long receiver
  // stall; allow many times that.
  localparam int IDLE_LIMIT   = 5000;
  localparam int TAIL_CYCLES  = 40;
  localparam int MAX_PRINTS   = 20;

  // Op value with no meaning; the block must answer it with a plain done.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [SYM_W-1:0]    sym;
  } trie_result_t;

  typedef struct {
    logic [OP_W-1:0]       op;
    logic [SYM_W-1:0]      sym;
    logic [CODE_LEN_W-1:0] len;
    logic [CODE_W-1:0]     code;
    logic                  b;
    bit                    typed;
    trie_result_t          res;
  } dir_row_t;

  // -------------------------------------------------------------------------
  // Clock, reset and block ports
  // -------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  req_valid   = 1'b0;
  logic                  req_stall;
  logic [OP_W-1:0]       op          = OP_CLEAR;
  logic [SYM_W-1:0]      symbol      = '0;
  logic [CODE_LEN_W-1:0] code_length = '0;
  logic [CODE_W-1:0]     code_value  = '0;
  logic                  bit_req     = 1'b0;
  logic                  res_valid;
  logic                  res_stall   = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [SYM_W-1:0]      decoded_symbol;

  always #4 clk = ~clk;

  huffman_trie_decoder_core #(
    .MAX_NODES    (MAX_NODES),
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_BITS  (SYM_W)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .op             (op),
    .symbol         (symbol),
    .code_length    (code_length),
    .code_value     (code_value),
    .bit_req        (bit_req),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .status         (status),
    .decoded_symbol (decoded_symbol)
  );

  // -------------------------------------------------------------------------
  // Trie model: own copy of the node store, allocation count and the
  // position of the bit-by-bit walk.
  // -------------------------------------------------------------------------
  logic [NODE_W-1:0] left_kid    [MAX_NODES];
  logic [NODE_W-1:0] right_kid   [MAX_NODES];
  logic              term_flag   [MAX_NODES];
  logic [SYM_W-1:0]  term_symbol [MAX_NODES];
  int                node_count;
  logic [NODE_W-1:0] walk_pos;

  function automatic void empty_node(int n);
    left_kid[n]    = '0;
    right_kid[n]   = '0;
    term_flag[n]   = 1'b0;
    term_symbol[n] = '0;
  endfunction

  // Walk the code from its top used bit down, growing missing children;
  // stop with a full status as soon as a child cannot be allocated.
  function automatic logic [STATUS_W-1:0] trie_insert(logic [SYM_W-1:0] sym,
                                                      logic [CODE_LEN_W-1:0] len,
                                                      logic [CODE_W-1:0] code);
    int   cur;
    int   steps;
    int   nxt;
    logic go_right;
    cur   = 0;
    steps = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len);
    for (int k = steps; k > 0; k--) begin
      go_right = (k - 1 < CODE_W) ? code[k-1] : 1'b0;
      nxt      = go_right ? int'(right_kid[cur]) : int'(left_kid[cur]);
      if (nxt == 0) begin
        if (node_count >= MAX_NODES) return ST_FULL;
        nxt = node_count;
        node_count++;
        empty_node(nxt);
        if (go_right) right_kid[cur] = NODE_W'(nxt);
        else left_kid[cur] = NODE_W'(nxt);
      end
      cur = nxt;
    end
    term_flag[cur]   = 1'b1;
    term_symbol[cur] = sym;
    return ST_DONE;
  endfunction

  function automatic trie_result_t trie_predict(logic [OP_W-1:0] rop,
                                                logic [SYM_W-1:0] sym,
                                                logic [CODE_LEN_W-1:0] len,
                                                logic [CODE_W-1:0] code,
                                                logic b);
    trie_result_t r;
    int           nxt;
    r = '{st: ST_DONE, sym: '0};
    case (rop)
      OP_CLEAR: begin
        node_count = 1;
        empty_node(0);
        walk_pos = '0;
      end
      OP_INSERT: begin
        r.st = trie_insert(sym, len, code);
      end
      OP_DECODE: begin
        // Step first, then look at the child: the root is never reported.
        nxt = b ? int'(right_kid[walk_pos]) : int'(left_kid[walk_pos]);
        if (nxt == 0) begin
          r.st = ST_DAMAGED;
        end else if (term_flag[nxt]) begin
          r.st     = ST_SYMBOL;
          r.sym    = term_symbol[nxt];
          walk_pos = '0;
        end else begin
          walk_pos = NODE_W'(nxt);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Checking: expected results in request order, plus a few counters.
  // -------------------------------------------------------------------------
  trie_result_t pending_results[$];
  int           mismatches = 0;
  int           results_seen = 0;
  int           idle_cycles = 0;
  int           n_symbols = 0, n_damaged = 0, n_full = 0, n_inserts = 0;
  int           n_decodes = 0, n_clears = 0;

  // Typed expectation of the request now on the bus, if any.
  bit           row_typed = 1'b0;
  trie_result_t row_result;

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] %s: got %0d, want %0d (result %0d)", $time, what, got, want,
               results_seen);
  endtask

  always @(posedge clk) begin
    trie_result_t want;
    trie_result_t pred;
    if (!rst) begin
      idle_cycles = idle_cycles + 1;
      // Retire a result against the oldest expectation.
      if (res_valid && !res_stall) begin
        idle_cycles = 0;
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request outstanding", int'(status), -1);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.st)
            report_mismatch("status", int'(status), int'(want.st));
          if (decoded_symbol !== want.sym)
            report_mismatch("decoded_symbol", int'(decoded_symbol), int'(want.sym));
          case (status)
            ST_SYMBOL:  n_symbols++;
            ST_DAMAGED: n_damaged++;
            ST_FULL:    n_full++;
            default: ;
          endcase
        end
      end
      // Advance the model on each accepted request; a typed row takes
      // precedence over the model's answer.
      if (req_valid && !req_stall) begin
        idle_cycles = 0;
        pred = trie_predict(op, symbol, code_length, code_value, bit_req);
        if (row_typed) pred = row_result;
        pending_results = {pending_results, pred};
        case (op)
          OP_CLEAR:  n_clears++;
          OP_INSERT: n_inserts++;
          OP_DECODE: n_decodes++;
          default: ;
        endcase
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: stall in modes that change every so often - free running,
  // light random, heavy random, a fixed rhythm, and long holds.
  // -------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 4);
        stall_left = $urandom_range(32, 200);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= ($urandom_range(0, 3) != 0);
        3: res_stall <= ((stall_tick % 7) < 3);
        default: res_stall <= ((stall_tick % 64) < 40);
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Sender: requests go out in bursts of random length with random gaps.
  // Every call starts and ends on a falling edge.
  // -------------------------------------------------------------------------
  int burst_left = 0;
  int reqs_sent  = 0;

  task automatic send_request(logic [OP_W-1:0] rop, int sym, int len, int code,
                              logic b, bit typed = 1'b0,
                              trie_result_t res = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_valid   <= 1'b1;
    op          <= rop;
    symbol      <= SYM_W'(sym);
    code_length <= CODE_LEN_W'(len);
    code_value  <= CODE_W'(code);
    bit_req     <= b;
    row_typed   <= typed;
    row_result  <= res;
    // Hold the request until the block takes it.
    do @(posedge clk); while (req_stall);
    if (rop != OP_UNUSED) reqs_sent++;
    @(negedge clk);
  endtask

  // Shorthand for the directed table.
  dir_row_t dir_rows[$];

  function automatic void add_row(logic [OP_W-1:0] rop, int sym, int len, int code,
                                  logic b, bit typed, logic [STATUS_W-1:0] st,
                                  int dsym);
    dir_row_t r;
    r.op    = rop;
    r.sym   = SYM_W'(sym);
    r.len   = CODE_LEN_W'(len);
    r.code  = CODE_W'(code);
    r.b     = b;
    r.typed = typed;
    r.res   = '{st: st, sym: SYM_W'(dsym)};
    dir_rows = {dir_rows, r};
  endfunction

  // Leaves of a random prefix code, grown by splitting.
  int leaf_len[64];
  int leaf_code[64];
  int leaf_sym[64];
  int leaf_n;

  task automatic build_prefix_code(int target, int max_len, bit deep);
    int idx;
    int guard;
    leaf_n = 1;
    leaf_len[0]  = 0;
    leaf_code[0] = 0;
    guard = 0;
    while (leaf_n < target && guard < 1000) begin
      // Deep codes keep splitting the newest leaf to reach long codewords.
      idx = deep ? leaf_n - 1 : $urandom_range(0, leaf_n - 1);
      if (leaf_len[idx] < max_len) begin
        leaf_len[leaf_n]  = leaf_len[idx] + 1;
        leaf_code[leaf_n] = leaf_code[idx] * 2 + 1;
        leaf_len[idx]++;
        leaf_code[idx] = leaf_code[idx] * 2;
        leaf_n++;
      end
      guard++;
    end
    for (int i = 0; i < leaf_n; i++) leaf_sym[i] = $urandom_range(0, (1 << SYM_W) - 1);
  endtask

  // Build a code table (a few entries left out to open damaged paths),
  // then stream codewords through it with the odd flipped bit and an
  // occasional insert in the middle of a walk.
  task automatic prefix_phase();
    int j;
    int words;
    bit deep;
    deep = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) != 0) send_request(OP_CLEAR, 0, 0, 0, 1'b0);
    build_prefix_code($urandom_range(2, 24), deep ? MAX_CODE_LEN : $urandom_range(3, 10),
                      deep);
    for (int i = 0; i < leaf_n; i++)
      if ($urandom_range(0, 11) != 0)
        send_request(OP_INSERT, leaf_sym[i], leaf_len[i], leaf_code[i],
                     1'($urandom_range(0, 1)));
    words = $urandom_range(5, 40);
    for (int w = 0; w < words; w++) begin
      // Stop streaming once the run has its share of requests.
      if (reqs_sent >= TARGET_REQS) break;
      j = $urandom_range(0, leaf_n - 1);
      for (int k = leaf_len[j] - 1; k >= 0; k--) begin
        if ($urandom_range(0, 29) == 0)
          send_request(OP_DECODE, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        else
          send_request(OP_DECODE, $urandom, $urandom, $urandom, leaf_code[j][k]);
        if ($urandom_range(0, 39) == 0)
          send_request(OP_INSERT, $urandom, $urandom_range(0, MAX_CODE_LEN), $urandom,
                       1'b0);
      end
    end
  endtask

  // Send a run of long random codes to overflow the store, then walk.
  task automatic fill_phase();
    send_request(OP_CLEAR, 0, 0, 0, 1'b0);
    repeat (120)
      send_request(OP_INSERT, $urandom, $urandom_range(12, 31), $urandom, 1'b0);
    repeat (20) send_request(OP_DECODE, 0, 0, 0, 1'($urandom_range(0, 1)));
  endtask

  task automatic noise_phase();
    repeat ($urandom_range(10, 30))
      send_request(OP_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                   1'($urandom));
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int phase;
    for (int n = 0; n < MAX_NODES; n++) empty_node(n);
    node_count = 1;
    walk_pos   = '0;

    // Hold reset, then release it on a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table: reset state, extremes and the corner cases.
    add_row(OP_DECODE, 0, 0, 0, 1'b0, 1, ST_DAMAGED, 0);          // empty trie
    add_row(OP_UNUSED, 511, 31, 'hFFFF, 1'b1, 1, ST_DONE, 0);     // unused op
    add_row(OP_INSERT, 511, 0, 0, 1'b0, 1, ST_DONE, 0);           // zero-length code
    add_row(OP_DECODE, 0, 0, 0, 1'b1, 1, ST_DAMAGED, 0);          // root never reported
    add_row(OP_DECODE, 0, 0, 0, 1'b0, 1, ST_DAMAGED, 0);
    add_row(OP_CLEAR, 0, 0, 0, 1'b0, 1, ST_DONE, 0);
    add_row(OP_INSERT, 511, 1, 1, 1'b0, 1, ST_DONE, 0);
    add_row(OP_INSERT, 0, 1, 0, 1'b0, 1, ST_DONE, 0);
    add_row(OP_DECODE, 0, 0, 0, 1'b1, 1, ST_SYMBOL, 511);
    add_row(OP_DECODE, 0, 0, 0, 1'b0, 1, ST_SYMBOL, 0);
    add_row(OP_INSERT, 3, 16, 'hFFFF, 1'b0, 1, ST_DONE, 0);       // through a terminal
    add_row(OP_DECODE, 0, 0, 0, 1'b1, 1, ST_SYMBOL, 511);         // stops at it first
    add_row(OP_INSERT, 'h155, 31, 0, 1'b0, 1, ST_DONE, 0);        // over-long length
    add_row(OP_INSERT, 'h0AA, 16, 'h8000, 1'b0, 1, ST_DONE, 0);
    add_row(OP_DECODE, 0, 0, 0, 1'b0, 1, ST_SYMBOL, 0);
    add_row(OP_CLEAR, 511, 31, 'hFFFF, 1'b1, 1, ST_DONE, 0);      // fields ignored
    add_row(OP_INSERT, 7, 2, 3, 1'b0, 1, ST_DONE, 0);
    add_row(OP_DECODE, 0, 0, 0, 1'b1, 1, ST_DONE, 0);             // interior node
    add_row(OP_DECODE, 0, 0, 0, 1'b0, 1, ST_DAMAGED, 0);          // missing child, stay
    add_row(OP_DECODE, 0, 0, 0, 1'b1, 1, ST_SYMBOL, 7);
    add_row(OP_INSERT, 9, 3, 6, 1'b0, 1, ST_DONE, 0);
    add_row(OP_DECODE, 0, 0, 0, 1'b1, 0, ST_DONE, 0);
    add_row(OP_DECODE, 0, 0, 0, 1'b1, 0, ST_DONE, 0);
    add_row(OP_DECODE, 0, 0, 0, 1'b0, 0, ST_DONE, 0);
    add_row(OP_CLEAR, 0, 0, 0, 1'b0, 1, ST_DONE, 0);
    foreach (dir_rows[i])
      send_request(dir_rows[i].op, int'(dir_rows[i].sym), int'(dir_rows[i].len),
                   int'(dir_rows[i].code), dir_rows[i].b, dir_rows[i].typed,
                   dir_rows[i].res);

    // Random phases, mostly well-formed code tables with streams behind them.
    phase = 0;
    while (reqs_sent < TARGET_REQS) begin
      if (phase % 8 == 1) fill_phase();
      else if ($urandom_range(0, 5) == 0) noise_phase();
      else prefix_phase();
      phase++;
    end
    req_valid <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results still outstanding", 0, pending_results.size());

    $display("Covered %0d requests: %0d inserts, %0d decode bits, %0d clears.",
             reqs_sent, n_inserts, n_decodes, n_clears);
    $display("Results: %0d symbols, %0d damaged paths, %0d store-full, %0d mismatches.",
             n_symbols, n_damaged, n_full, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
